[sv/assert_macros.svh]
// Assertion macros of the statement token splitter, included by its controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the house clock and reset, clk_i and rst_ni.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

[sv/stsp_pkg.sv]
// Shared types, constants and character-class functions of the token splitter.
package stsp_pkg;

  localparam int unsigned TOKEN_MAX_DEF = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [1:0] {
    MODE_WS  = 2'd0,
    MODE_AN  = 2'd1,
    MODE_OTH = 2'd2,
    MODE_STR = 2'd3
  } scan_mode_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_MEM  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_LIT  = 7'b0100000,
    S_NL   = 7'b1000000
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic idx_inc;
    logic skip_dec;
    logic upd;
    logic load_mem;
    logic load_lit;
    logic load_nl;
  } stsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_pend;
    logic is_sq;
    logic lit;
    logic emit_pend;
    logic mem_last;
    logic lit_last;
    logic nl;
    logic out_free;
  } stsp_sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c <= CH_SPACE;
  endfunction

  function automatic logic is_an(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic scan_mode_e classify(input logic [7:0] c);
    if (is_ws(c)) return MODE_WS;
    return is_an(c) ? MODE_AN : MODE_OTH;
  endfunction

endpackage

[sv/stsp_datapath.sv]
// Datapath of the token splitter: character registers, scan state, token memory, output register.
module stsp_datapath import stsp_pkg::*; #(
  parameter int unsigned TokenMax = TOKEN_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_now_i,
  input  logic [7:0] ahead_one_i,
  input  logic [7:0] ahead_two_i,
  input  logic [7:0] ahead_three_i,
  input  stsp_cmd_t  cmd_i,
  output stsp_sts_t  sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] token_byte_o,
  output logic       token_end_o,
  output logic       token_cut_o
);

  localparam int unsigned LenW = $clog2(TokenMax + 1);
  localparam int unsigned IdxW = $clog2(TokenMax);

  logic [7:0]      c_q, a1_q, a2_q, a3_q;
  scan_mode_e      mode_q;
  logic [LenW-1:0] len_q;
  logic            ovf_q;
  logic [1:0]      skip_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      store_q [TokenMax];
  logic [7:0]      rdata_q;
  logic            out_valid_q, out_end_q, out_cut_q;
  logic [7:0]      out_byte_q;

  logic            is_sq, is_dq, close_str, open_str;
  logic [7:0]      eff_c;
  logic            ws, an, punct, emit, drop_only, clear;
  scan_mode_e      m1, m2;
  logic            lit4, lit3;
  logic [LenW-1:0] base_len;
  logic            base_ovf, fits;
  logic            mem_we;
  logic [IdxW-1:0] mem_addr;
  logic [7:0]      mem_wdata;
  logic [7:0]      lit_byte;

  always_comb begin
    is_sq     = (c_q == CH_SQ);
    is_dq     = (c_q == CH_DQ);
    close_str = is_dq && (mode_q == MODE_STR);
    open_str  = is_dq && (mode_q != MODE_STR);
    eff_c     = close_str ? a1_q : c_q;
    ws        = is_ws(eff_c);
    an        = is_an(eff_c);
    punct     = (eff_c == CH_LPAR) || (eff_c == CH_RPAR) || (eff_c == CH_COMMA);
    if (close_str) begin
      m1 = classify(a1_q);
    end else if (open_str) begin
      m1 = MODE_STR;
    end else begin
      m1 = mode_q;
    end
    // Outside a string every mode change lands on the class of the character.
    m2        = (m1 == MODE_STR) ? MODE_STR : classify(eff_c);
    emit      = close_str || ((m1 == MODE_AN) && !an) ||
                ((m1 == MODE_OTH) && (an || ws || punct));
    drop_only = open_str || ((m1 == MODE_WS) && !ws);
    clear     = emit || drop_only;
    base_len  = clear ? '0 : len_q;
    base_ovf  = clear ? 1'b0 : ovf_q;
    fits      = base_len < LenW'(TokenMax);
    lit4      = (a1_q == CH_BSL) && (a3_q == CH_SQ) && (a2_q != CH_NUL);
    lit3      = !lit4 && (a2_q == CH_SQ) && (a1_q != CH_NUL);
  end

  always_comb begin
    if (is_sq) begin
      mem_we    = cmd_i.upd && !(lit4 || lit3);
      mem_addr  = '0;
      mem_wdata = CH_SQ;
    end else begin
      mem_we    = cmd_i.upd && (eff_c != CH_NUL) && fits;
      mem_addr  = base_len[IdxW-1:0];
      mem_wdata = eff_c;
    end
  end

  always_comb begin
    case (idx_q[1:0])
      2'd0:    lit_byte = c_q;
      2'd1:    lit_byte = a1_q;
      2'd2:    lit_byte = a2_q;
      default: lit_byte = a3_q;
    endcase
  end

  always_comb begin
    sts_o.skip_pend = (skip_q != 2'd0);
    sts_o.is_sq     = is_sq;
    sts_o.lit       = lit4 || lit3;
    sts_o.emit_pend = emit && (len_q != '0);
    sts_o.mem_last  = (LenW'(idx_q) + LenW'(1)) == len_q;
    sts_o.lit_last  = (idx_q[1:0] == (lit4 ? 2'd3 : 2'd2));
    sts_o.nl        = (eff_c == CH_NL);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      c_q  <= char_now_i;
      a1_q <= ahead_one_i;
      a2_q <= ahead_two_i;
      a3_q <= ahead_three_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= store_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AN;
      len_q  <= '0;
      ovf_q  <= 1'b0;
      skip_q <= 2'd0;
    end else if (cmd_i.skip_dec) begin
      skip_q <= skip_q - 2'd1;
    end else if (cmd_i.upd) begin
      if (is_sq) begin
        len_q <= mem_we ? LenW'(1) : '0;
        ovf_q <= 1'b0;
        if (lit4) begin
          skip_q <= 2'd3;
        end else if (lit3) begin
          skip_q <= 2'd2;
        end else begin
          skip_q <= 2'd0;
        end
      end else begin
        skip_q <= close_str ? 2'd1 : 2'd0;
        if (eff_c == CH_NUL) begin
          mode_q <= MODE_AN;
          len_q  <= '0;
          ovf_q  <= 1'b0;
        end else begin
          mode_q <= m2;
          if (fits) begin
            len_q <= base_len + LenW'(1);
            ovf_q <= base_ovf;
          end else begin
            len_q <= base_len;
            ovf_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.latch) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_mem || cmd_i.load_lit || cmd_i.load_nl) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mem) begin
      out_byte_q <= rdata_q;
      out_end_q  <= sts_o.mem_last;
      out_cut_q  <= ovf_q;
    end else if (cmd_i.load_lit) begin
      out_byte_q <= lit_byte;
      out_end_q  <= sts_o.lit_last;
      out_cut_q  <= 1'b0;
    end else if (cmd_i.load_nl) begin
      out_byte_q <= CH_NL;
      out_end_q  <= 1'b1;
      out_cut_q  <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign token_byte_o = out_byte_q;
  assign token_end_o  = out_end_q;
  assign token_cut_o  = out_cut_q;

endmodule

[sv/stsp_ctrl.sv]
// Controller state machine of the token splitter.
`include "assert_macros.svh"

module stsp_ctrl import stsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  stsp_sts_t sts_i,
  output stsp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.skip_pend) begin
          cmd_o.skip_dec = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.is_sq) begin
          if (sts_i.lit) begin
            state_d = S_LIT;
          end else begin
            cmd_o.upd = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (sts_i.emit_pend) begin
          state_d = S_RD;
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = sts_i.nl ? S_NL : S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_MEM;
      end
      S_MEM: begin
        if (sts_i.out_free) begin
          cmd_o.load_mem = 1'b1;
          if (sts_i.mem_last) begin
            state_d = S_UPD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.nl ? S_NL : S_IDLE;
      end
      S_LIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_lit = 1'b1;
          if (sts_i.lit_last) begin
            cmd_o.upd = 1'b1;
            state_d   = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_NL: begin
        if (sts_i.out_free) begin
          cmd_o.load_nl = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_STD(a_accept_decides, (in_valid_i && in_ready_o) |=> (state_q == S_DEC), "accepted transaction not decoded")
  `ASSERT_STD(a_load_when_free, (cmd_o.load_mem || cmd_o.load_lit || cmd_o.load_nl) |-> sts_i.out_free, "output register overwritten")
  `ASSERT_STD(a_single_load, $onehot0({cmd_o.load_mem, cmd_o.load_lit, cmd_o.load_nl}), "several output loads at once")
  `ASSERT_STD(a_skip_only_pending, cmd_o.skip_dec |-> sts_i.skip_pend, "skip count decremented below zero")

endmodule

[sv/statement_token_splitter.sv]
// Top level of the statement token splitter: controller and datapath joined.
// An item that emits nothing passes through accept (S_IDLE) and decode (S_DEC) before the next is taken.
// A pending token is sent byte by byte (token memory read in S_RD, output load in S_MEM), then S_UPD follows.
// A char literal is loaded byte by byte in S_LIT, a newline token in S_NL; output stalls hold the load states.
// A new item is taken only after the controller has returned to S_IDLE, so items do not overlap.
// Reset (rst_ni, asynchronous, active low) empties the token and output; the memory is not cleared.
module statement_token_splitter import stsp_pkg::*; #(
  parameter int unsigned TokenMax = TOKEN_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_now_i,
  input  logic [7:0] ahead_one_i,
  input  logic [7:0] ahead_two_i,
  input  logic [7:0] ahead_three_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] token_byte_o,
  output logic       token_end_o,
  output logic       token_cut_o
);

  // Commands flow from the controller to the datapath, status flows back.
  stsp_cmd_t cmd;
  stsp_sts_t sts;

  // The controller accepts one input transaction at a time, decides in the following cycle
  // whether the pending token, a char literal or a newline token has to be emitted, and
  // then walks through the output bytes one transaction at a time.
  stsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the scan mode, the pending token in a small memory and the output
  // register, which lets a finished byte wait while the next input transaction is taken.
  stsp_datapath #(
    .TokenMax (TokenMax)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_now_i    (char_now_i),
    .ahead_one_i   (ahead_one_i),
    .ahead_two_i   (ahead_two_i),
    .ahead_three_i (ahead_three_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .token_byte_o  (token_byte_o),
    .token_end_o   (token_end_o),
    .token_cut_o   (token_cut_o)
  );

endmodule
